>>> rtl/pdfls_pkg.sv
`default_nettype none

package pdfls_pkg;

  // Delimiters and control bytes
  localparam logic [7:0] CH_OPEN   = 8'h28;
  localparam logic [7:0] CH_CLOSE  = 8'h29;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_BS     = 8'h08;
  localparam logic [7:0] CH_FF     = 8'h0C;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_SEVEN  = 8'h37;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_F      = 8'h66;

  localparam int unsigned          LEN_W       = 16;
  localparam logic [LEN_W-1:0]     MAX_LEN_RST = 16'd255;
  // third octal digit closes the escape
  localparam logic [1:0]           OCT_LAST    = 2'd2;

  // One decoded input byte: optional data in slot a (octal flush),
  // then optional data or end marker in slot b.
  typedef struct packed {
    logic       has_a;
    logic [7:0] a_byte;
    logic       has_b;
    logic       b_end;
    logic [7:0] b_byte;
  } cmd_t;

  typedef struct packed {
    logic [7:0] data;
    logic       eos;
    logic       ovf;
  } res_t;

endpackage

`default_nettype wire

>>> rtl/pdfls_fifo.sv
`default_nettype none

module pdfls_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wdata,
  output logic                  full,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      rdata,
  output logic                  empty
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign full  = (cnt_r == CNT_W'(DEPTH));
  assign empty = (cnt_r == '0);
  assign rdata = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n) !(push && full))
    else $error("word pushed into full queue");
  a_no_underrun: assert property (@(posedge clk) disable iff (!rst_n) !(pop && empty))
    else $error("word popped from empty queue");
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
                                cnt_r <= CNT_W'(DEPTH))
    else $error("queue fill count out of range");
  a_cnt_track: assert property (@(posedge clk) disable iff (!rst_n)
                                (push && !pop) |=> (cnt_r == $past(cnt_r) + 1'b1))
    else $error("fill count missed a push");

endmodule

`default_nettype wire

>>> rtl/pdfls_front.sv
`default_nettype none

module pdfls_front #(
  parameter int unsigned NEST_WIDTH = 8
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         accept,
  input  wire logic [7:0]   in_byte,
  output logic              cmd_push,
  output pdfls_pkg::cmd_t   cmd
);

  import pdfls_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_BODY   = 5'b00010,
    ST_ESC    = 5'b00100,
    ST_OCTAL  = 5'b01000,
    ST_CONTCR = 5'b10000
  } state_t;

  state_t                state_r, state_nxt;
  logic [NEST_WIDTH-1:0] nest_r, nest_nxt;
  logic [7:0]            oval_r, oval_nxt;
  logic [1:0]            odig_r, odig_nxt;

  logic       is_oct;
  logic       do_body;
  logic [7:0] oct_acc;

  assign is_oct  = (in_byte >= CH_ZERO) && (in_byte <= CH_SEVEN);
  assign oct_acc = {oval_r[4:0], in_byte[2:0]};

  always_comb begin
    state_nxt = state_r;
    nest_nxt  = nest_r;
    oval_nxt  = oval_r;
    odig_nxt  = odig_r;
    cmd       = '0;
    do_body   = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (in_byte == CH_OPEN) begin
          state_nxt = ST_BODY;
          nest_nxt  = '0;
          oval_nxt  = '0;
          odig_nxt  = '0;
        end
      end
      ST_ESC: begin
        state_nxt = ST_BODY;
        if (is_oct) begin
          oval_nxt  = {5'd0, in_byte[2:0]};
          odig_nxt  = 2'd1;
          state_nxt = ST_OCTAL;
        end else begin
          cmd.has_b  = 1'b1;
          cmd.b_byte = in_byte;
          case (in_byte)
            CH_N:    cmd.b_byte = CH_LF;
            CH_R:    cmd.b_byte = CH_CR;
            CH_T:    cmd.b_byte = CH_TAB;
            CH_B:    cmd.b_byte = CH_BS;
            CH_F:    cmd.b_byte = CH_FF;
            CH_LF:   cmd.has_b  = 1'b0;
            CH_CR: begin
              cmd.has_b = 1'b0;
              state_nxt = ST_CONTCR;
            end
            default: cmd.b_byte = in_byte;
          endcase
        end
      end
      ST_OCTAL: begin
        if (is_oct) begin
          if (odig_r == OCT_LAST) begin
            cmd.has_b  = 1'b1;
            cmd.b_byte = oct_acc;
            oval_nxt   = '0;
            odig_nxt   = '0;
            state_nxt  = ST_BODY;
          end else begin
            oval_nxt = oct_acc;
            odig_nxt = odig_r + 1'b1;
          end
        end else begin
          // flush the short escape, then the byte counts as plain body
          cmd.has_a  = 1'b1;
          cmd.a_byte = oval_r;
          oval_nxt   = '0;
          odig_nxt   = '0;
          do_body    = 1'b1;
        end
      end
      ST_CONTCR: begin
        if (in_byte == CH_LF) begin
          state_nxt = ST_BODY;
        end else begin
          do_body = 1'b1;
        end
      end
      ST_BODY: do_body = 1'b1;
      default: begin
        state_nxt = ST_IDLE;
        nest_nxt  = '0;
        oval_nxt  = '0;
        odig_nxt  = '0;
      end
    endcase

    if (do_body) begin
      state_nxt = ST_BODY;
      if (in_byte == CH_OPEN) begin
        if (nest_r != '1) begin
          nest_nxt = nest_r + 1'b1;
        end
        cmd.has_b  = 1'b1;
        cmd.b_byte = in_byte;
      end else if (in_byte == CH_CLOSE) begin
        cmd.has_b = 1'b1;
        if (nest_r == '0) begin
          cmd.b_end = 1'b1;
          state_nxt = ST_IDLE;
        end else begin
          nest_nxt   = nest_r - 1'b1;
          cmd.b_byte = in_byte;
        end
      end else if (in_byte == CH_BSLASH) begin
        state_nxt = ST_ESC;
      end else begin
        cmd.has_b  = 1'b1;
        cmd.b_byte = in_byte;
      end
    end
  end

  assign cmd_push = accept && (cmd.has_a || cmd.has_b);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      nest_r  <= '0;
      oval_r  <= '0;
      odig_r  <= '0;
    end else if (accept) begin
      state_r <= state_nxt;
      nest_r  <= nest_nxt;
      oval_r  <= oval_nxt;
      odig_r  <= odig_nxt;
    end
  end

  a_end_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
                                  (cmd_push && cmd.b_end) |=> (state_r == ST_IDLE))
    else $error("end marker without return to idle");
  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
                                 (state_r == ST_IDLE) |-> !cmd_push)
    else $error("word issued while idle");
  a_slot_a_octal: assert property (@(posedge clk) disable iff (!rst_n)
                                   (cmd_push && cmd.has_a) |-> (state_r == ST_OCTAL))
    else $error("octal flush outside octal escape");

endmodule

`default_nettype wire

>>> rtl/pdfls_back.sv
`default_nettype none

module pdfls_back (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        cmd_empty,
  input  wire pdfls_pkg::cmd_t             cmd,
  output logic                             cmd_pop,
  input  wire logic                        res_full,
  output logic                             res_push,
  output pdfls_pkg::res_t                  res,
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [pdfls_pkg::LEN_W-1:0] cfg_data
);

  import pdfls_pkg::*;

  logic             sel_r, sel_nxt;
  logic [LEN_W-1:0] count_r, count_nxt;
  logic             dropped_r, dropped_nxt;
  logic [LEN_W-1:0] max_len_r;

  logic       go;
  logic       use_a;
  logic       is_end;
  logic       keep;
  logic [7:0] data;

  assign cfg_ready = 1'b1;

  always_comb begin
    go     = !cmd_empty && !res_full;
    use_a  = !sel_r && cmd.has_a;
    is_end = !use_a && cmd.b_end;
    data   = use_a ? cmd.a_byte : cmd.b_byte;
    keep   = (count_r < max_len_r);

    cmd_pop  = go && !(use_a && cmd.has_b);
    sel_nxt  = go ? (use_a && cmd.has_b) : sel_r;
    res_push = go && (is_end || keep);

    if (is_end) begin
      res = '{data: 8'd0, eos: 1'b1, ovf: dropped_r};
    end else begin
      res = '{data: data, eos: 1'b0, ovf: 1'b0};
    end

    count_nxt   = count_r;
    dropped_nxt = dropped_r;
    if (go) begin
      if (is_end) begin
        count_nxt   = '0;
        dropped_nxt = 1'b0;
      end else if (keep) begin
        count_nxt = count_r + 1'b1;
      end else begin
        dropped_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sel_r     <= 1'b0;
      count_r   <= '0;
      dropped_r <= 1'b0;
      max_len_r <= MAX_LEN_RST;
    end else begin
      sel_r     <= sel_nxt;
      count_r   <= count_nxt;
      dropped_r <= dropped_nxt;
      if (cfg_valid && cfg_ready) begin
        max_len_r <= cfg_data;
      end
    end
  end

  a_sel_hold: assert property (@(posedge clk) disable iff (!rst_n)
                               (go && use_a && cmd.has_b) |-> !cmd_pop)
    else $error("two-slot word popped before its second slot");
  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
                                 (go && is_end) |=> (count_r == '0 && !dropped_r))
    else $error("end marker left count or drop flag set");
  a_drop_sticky: assert property (@(posedge clk) disable iff (!rst_n)
                                  (dropped_r && !(go && is_end)) |=> dropped_r)
    else $error("drop flag lost before end marker");

endmodule

`default_nettype wire

>>> rtl/pdf_literal_string_decoder.sv
`default_nettype none

// PDF literal string decoder.
// Input: raw content-stream bytes on in_byte, taken when push is high and
//   full is low. Bytes outside a string are ignored until '(' opens one.
// Results: while empty is low the oldest word sits on out_byte,
//   out_end_of_string and out_overflowed; pop takes it. A data word carries
//   one decoded byte; the closing ')' gives an end word (out_byte zero)
//   whose out_overflowed says bytes beyond max_length were dropped.
// Config: cfg_data is written to max_length when cfg_valid is high
//   (cfg_ready is always high). Write it only while the block is idle.
// Path: a decoded word is written to the command queue when its input byte
//   is taken (decode in the accepting cycle); the limiter then moves it into
//   the result queue, where it sits on the result ports for pop to take.
// Throughput: one input byte per cycle while full is low. A byte ending
//   a short octal escape may yield two words; the limiter handles one word
//   per cycle when the result queue has room, so full can rise after it.
// Stall: if pop stays low the result queue fills, the limiter stops, the
//   command queue fills and full rises; nothing is lost.
// Reset: rst_n low at a clock edge empties both queues, returns to idle
//   and sets max_length back to 255.
module pdf_literal_string_decoder #(
  parameter int unsigned NEST_WIDTH = 8
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        push,
  output logic             full,
  input  wire logic [7:0]  in_byte,
  output logic             empty,
  input  wire logic        pop,
  output logic [7:0]       out_byte,
  output logic             out_end_of_string,
  output logic             out_overflowed,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [15:0] cfg_data
);

  import pdfls_pkg::*;

  localparam int unsigned CMD_W = $bits(cmd_t);
  localparam int unsigned RES_W = $bits(res_t);

  logic  accept;
  logic  cmd_push, cmd_pop, cmd_full, cmd_empty;
  cmd_t  cmd_in, cmd_out;
  logic  res_push, res_full;
  res_t  res_in, res_out;

  assign accept = push && !full;
  assign full   = cmd_full;

  // front: escape / nesting state machine
  pdfls_front #(
    .NEST_WIDTH (NEST_WIDTH)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (accept),
    .in_byte  (in_byte),
    .cmd_push (cmd_push),
    .cmd      (cmd_in)
  );

  // decoupling queue between decode and limiter
  pdfls_fifo #(
    .WIDTH (CMD_W),
    .DEPTH (2)
  ) u_cmd_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (cmd_push),
    .wdata (cmd_in),
    .full  (cmd_full),
    .pop   (cmd_pop),
    .rdata (cmd_out),
    .empty (cmd_empty)
  );

  // back: length limiter, end marker, config register
  pdfls_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_empty (cmd_empty),
    .cmd       (cmd_out),
    .cmd_pop   (cmd_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res       (res_in),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  // result queue parts limiter from the consumer
  pdfls_fifo #(
    .WIDTH (RES_W),
    .DEPTH (2)
  ) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (res_in),
    .full  (res_full),
    .pop   (pop && !empty),
    .rdata (res_out),
    .empty (empty)
  );

  assign out_byte          = res_out.data;
  assign out_end_of_string = res_out.eos;
  assign out_overflowed    = res_out.ovf;

endmodule

`default_nettype wire
